>>> sv/hsk_pkg.sv
// Package for the Hamming(15,11) key reconciliation block.
// Key and group sizes, key mask and codeword data positions.
// No dependencies.
package hsk_pkg;

    localparam int KEY_BITS   = 64;
    localparam int GROUP_BITS = 11;
    localparam int MAX_GROUPS = 6;
    localparam int SYN_BITS   = 4;

    localparam int GROUPS_RAW = (KEY_BITS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int GROUPS     = (GROUPS_RAW > MAX_GROUPS) ? MAX_GROUPS : GROUPS_RAW;
    localparam int PAD_BITS   = GROUPS * GROUP_BITS;

    // key ports are 64 bits wide; bits at or above KEY_BITS are dropped
    localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);

    typedef logic [SYN_BITS-1:0]   syn_t;
    typedef logic [GROUP_BITS-1:0] group_t;

    // codeword position of each data bit; parity sits at 1, 2, 4 and 8
    localparam syn_t DATA_POS [GROUP_BITS] = '{
        4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

endpackage

>>> sv/hsk_group.sv
// One 11-bit group: syndrome from the differing data bits and single-bit fix.
// Depends on hsk_pkg.
module hsk_group
(
    input  hsk_pkg::group_t ref_data,
    input  hsk_pkg::group_t noisy_data,
    output hsk_pkg::group_t corr_data
);

    hsk_pkg::group_t diff;
    hsk_pkg::syn_t   syndrome;

    assign diff = ref_data ^ noisy_data;

    // parity from the reference against parity from the noisy data reduces
    // to the XOR of the positions where the data differs
    always_comb
    begin
        syndrome = '0;
        for (int j = 0; j < hsk_pkg::GROUP_BITS; j++)
        begin
            if (diff[j])
            begin
                syndrome = syndrome ^ hsk_pkg::DATA_POS[j];
            end
        end
    end

    // a syndrome on a parity position matches no data position: no change
    always_comb
    begin
        for (int j = 0; j < hsk_pkg::GROUP_BITS; j++)
        begin
            corr_data[j] = noisy_data[j] ^ (syndrome == hsk_pkg::DATA_POS[j]);
        end
    end

endmodule

>>> sv/hamming_syndrome_key_reconciliation.sv
// Top level of the Hamming(15,11) key reconciliation block.
// Depends on hsk_pkg and hsk_group.
//
// A key pair is taken on every edge where start is high; busy never rises, so
// one pair can be transferred each cycle. The corrected key passes the input
// register, then the six group correctors into the result register, and is
// shown on fixed_key with a one-cycle done strobe. The receiver cannot stall, so
// each result must be captured in its strobe cycle.
module hamming_syndrome_key_reconciliation
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] reference_key,
    input  logic [63:0] noisy_key,
    output logic [63:0] fixed_key,
    output logic        done
);

    logic        valid_reg;
    logic [63:0] ref_reg;
    logic [63:0] noisy_reg;
    logic        done_reg;
    logic [63:0] result_reg;
    logic [63:0] result_next;

    logic [hsk_pkg::PAD_BITS-1:0] ref_pad;
    logic [hsk_pkg::PAD_BITS-1:0] noisy_pad;
    logic [hsk_pkg::PAD_BITS-1:0] corr_pad;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            ref_reg   <= reference_key;
            noisy_reg <= noisy_key;
        end
        if (valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // zero padding up to whole groups
    assign ref_pad   = hsk_pkg::PAD_BITS'(ref_reg & hsk_pkg::KEY_MASK);
    assign noisy_pad = hsk_pkg::PAD_BITS'(noisy_reg & hsk_pkg::KEY_MASK);

    for (genvar g = 0; g < hsk_pkg::GROUPS; g++)
    begin : g_group
        hsk_group u_group
        (
            .ref_data   (ref_pad[g*hsk_pkg::GROUP_BITS +: hsk_pkg::GROUP_BITS]),
            .noisy_data (noisy_pad[g*hsk_pkg::GROUP_BITS +: hsk_pkg::GROUP_BITS]),
            .corr_data  (corr_pad[g*hsk_pkg::GROUP_BITS +: hsk_pkg::GROUP_BITS])
        );
    end

    // flips on padding positions fall away here
    assign result_next = 64'(corr_pad) & hsk_pkg::KEY_MASK;

    assign fixed_key = result_reg;
    assign done      = done_reg;

endmodule

>>> sv/hsk_checker.sv
// Port-level checks for the key reconciliation block, bound to the top level.
// Depends on hsk_pkg and hamming_syndrome_key_reconciliation.
module hsk_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [63:0] reference_key,
    input logic [63:0] noisy_key,
    input logic [63:0] fixed_key,
    input logic        done
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n, 1) && $past(rst_n, 2)) |-> (done == $past(start, 2)))
        else $error("done does not follow start by two cycles");

    a_equal_keys_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(rst_n, 1) && $past(rst_n, 2)
            && ($past(reference_key, 2) == $past(noisy_key, 2)))
        |-> (fixed_key == ($past(noisy_key, 2) & hsk_pkg::KEY_MASK)))
        else $error("matching keys were altered");

    a_one_fix_per_group: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(rst_n, 1) && $past(rst_n, 2))
        |-> ($countones(fixed_key ^ ($past(noisy_key, 2) & hsk_pkg::KEY_MASK))
            <= hsk_pkg::GROUPS))
        else $error("more bits flipped than there are groups");

endmodule

bind hamming_syndrome_key_reconciliation hsk_checker u_hsk_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .reference_key (reference_key),
    .noisy_key     (noisy_key),
    .fixed_key     (fixed_key),
    .done          (done)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for hamming_syndrome_key_reconciliation: directed and random key pairs,
// each corrected key checked against a local per-group syndrome predictor.
// Depends on hsk_pkg and the block's RTL.
module tb;

    // codeword position of each data bit in a group
    localparam logic [3:0] CODE_POS [11] = '{
        4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [63:0] reference_key = '0;
    logic [63:0] noisy_key = '0;
    logic        busy;
    logic [63:0] fixed_key;
    logic        done;

    logic [63:0] expected_keys [$];
    int          fail_count = 0;
    bit          sender_idles = 1'b1;

    hamming_syndrome_key_reconciliation u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .reference_key (reference_key),
        .noisy_key     (noisy_key),
        .fixed_key     (fixed_key),
        .done          (done)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [63:0] predict_corrected(input logic [63:0] ref_k,
                                                      input logic [63:0] noisy_k);
        logic [63:0] r;
        logic [63:0] n;
        logic [63:0] fixed;
        logic [3:0]  syn;
        logic        flip_bit;
        int          idx;
        r = ref_k & hsk_pkg::KEY_MASK;
        n = noisy_k & hsk_pkg::KEY_MASK;
        fixed = '0;
        for (int g = 0; g < hsk_pkg::GROUPS; g++)
        begin
            syn = '0;
            // padding bits are zero in both keys, so they never add to the syndrome
            for (int j = 0; j < hsk_pkg::GROUP_BITS; j++)
            begin
                idx = g * hsk_pkg::GROUP_BITS + j;
                if (idx < 64 && r[idx] != n[idx])
                    syn ^= CODE_POS[j];
            end
            // a syndrome on a parity or padding position changes nothing
            for (int j = 0; j < hsk_pkg::GROUP_BITS; j++)
            begin
                idx = g * hsk_pkg::GROUP_BITS + j;
                if (idx < 64)
                begin
                    flip_bit = n[idx];
                    if (syn != 4'd0 && syn == CODE_POS[j])
                        flip_bit = ~flip_bit;
                    fixed[idx] = flip_bit;
                end
            end
        end
        return fixed & hsk_pkg::KEY_MASK;
    endfunction

    // up to three flipped data bits per group, mostly zero or one
    function automatic logic [63:0] random_flip_mask();
        logic [63:0] mask;
        int          flips;
        int          pick;
        int          idx;
        mask = '0;
        for (int g = 0; g < hsk_pkg::GROUPS; g++)
        begin
            pick = $urandom_range(0, 99);
            flips = (pick < 30) ? 0 : (pick < 70) ? 1 : (pick < 90) ? 2 : 3;
            for (int k = 0; k < flips; k++)
            begin
                idx = g * hsk_pkg::GROUP_BITS + $urandom_range(0, hsk_pkg::GROUP_BITS - 1);
                if (idx < 64)
                    mask[idx] = ~mask[idx];
            end
        end
        return mask;
    endfunction

    function automatic logic [63:0] random_key();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_key_pair(input logic [63:0] ref_k, input logic [63:0] noisy_k);
        while (sender_idles && $urandom_range(0, 99) < 37)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        reference_key <= ref_k;
        noisy_key     <= noisy_k;
        do
            @(posedge clk);
        while (busy);
        expected_keys.push_back(predict_corrected(ref_k, noisy_k));
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_keys.size() != 0)
            @(posedge clk);
    endtask

    // results cannot be held off, so every done cycle is a transfer
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && done)
        begin
            if (expected_keys.size() == 0)
            begin
                $error("unexpected result: fixed_key actual %h", fixed_key);
                fail_count++;
            end
            else
            begin
                want = expected_keys.pop_front();
                if (fixed_key !== want)
                begin
                    $error("fixed_key mismatch: expected %h actual %h", want,
                           fixed_key);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_extremes();
        send_key_pair('0, '0);
        send_key_pair('1, '1);
        send_key_pair('0, '1);
        send_key_pair('1, '0);
        send_key_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_key_pair(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
    endtask

    task automatic test_single_errors();
        logic [63:0] base;
        base = random_key();
        send_key_pair(base, base ^ 64'h1);
        send_key_pair(base, base ^ (64'h1 << 63));
        // flips at or next to the first or last data bit of the groups, at most two per group
        send_key_pair(base, base ^ 64'h8040_1002_0040_0801);
        send_key_pair(base, base ^ 64'h0020_0400_8010_0400);
        send_key_pair(base, base);
    endtask

    task automatic test_multi_errors();
        logic [63:0] base;
        base = random_key();
        // positions 5 and 7 differ: syndrome lands on parity position 2
        send_key_pair(base, base ^ 64'h0000_0000_0000_000A);
        // last group, positions 3 and 13: syndrome 14 is a padding position
        send_key_pair(base, base ^ ((64'h1 << 55) | (64'h1 << 63)));
        // last group, positions 3 and 12: syndrome 15 is a padding position
        send_key_pair(base, base ^ ((64'h1 << 55) | (64'h1 << 62)));
        // three or more errors in one group: not corrected, and no flag is raised
        send_key_pair(base, base ^ 64'h0000_0000_0000_0007);
        send_key_pair(base, base ^ 64'h0000_0000_0038_0700);
        send_key_pair('0, 64'h7FF);
    endtask

    task automatic test_random_traffic(input int count);
        logic [63:0] ref_k;
        logic [63:0] noisy_k;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_for_results();
            ref_k = random_key();
            pick = $urandom_range(0, 99);
            if (pick < 85)
                noisy_k = ref_k ^ random_flip_mask();
            else if (pick < 95)
                noisy_k = random_key();
            else
            begin
                ref_k = (pick < 97) ? '0 : '1;
                noisy_k = random_key();
            end
            send_key_pair(ref_k, noisy_k);
        end
    endtask

    task automatic test_back_to_back(input int count);
        logic [63:0] ref_k;
        sender_idles = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            ref_k = random_key();
            send_key_pair(ref_k, ref_k ^ random_flip_mask());
        end
        sender_idles = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_single_errors();
        test_multi_errors();
        test_random_traffic(1400);
        test_back_to_back(300);
        wait_for_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("hamming_syndrome_key_reconciliation test passed");
        else
            $display("hamming_syndrome_key_reconciliation test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("hamming_syndrome_key_reconciliation test failed");
        $finish;
    end

endmodule
